// ===== rtl/dtw_pkg.sv =====
package dtw_pkg;

    // Fixed port widths of one transaction
    localparam int GATE_PORT_BITS = 16;
    localparam int DELAY_BITS     = 6;
    localparam int TIME_BITS      = 48;

    // Command codes
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_FETCH  = 1'b1
    } t_cmd;

endpackage

// ===== rtl/delay_timing_wheel.sv =====
// Insert: the accept moves to S_INS, which registers the result strobe; busy drops in that same strobe cycle.
// Fetch: the scan reads one meta word per slot (pipelined) and steps past empty slots to a hit, then S_POP
// registers the result; an empty wheel ends the scan after a full turn and rewinds the position to slot 0.
// Throughput is one transaction at a time, bounded by the per-slot scan of the meta memory.
// After reset the meta memory is swept clear slot by slot with busy high.
// Results are single-cycle strobes on o_done; the receiver cannot stall.
module delay_timing_wheel
    import dtw_pkg::*;
#(
    parameter int SLOTS        = 64,
    parameter int SLOT_DEPTH   = 16,
    parameter int GATE_ID_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_cmd,
    input  logic [GATE_PORT_BITS-1:0] i_gate_id,
    input  logic [DELAY_BITS-1:0]     i_delay,
    output logic                      o_done,
    output logic                      o_found,
    output logic [GATE_PORT_BITS-1:0] o_next_gate,
    output logic [TIME_BITS-1:0]      o_time_now,
    output logic                      o_overflow
);

    localparam int SB = $clog2(SLOTS);
    localparam int HB = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int CB = $clog2(SLOT_DEPTH + 1);
    localparam int AB = $clog2(SLOTS * SLOT_DEPTH);
    localparam int GW = GATE_ID_BITS;

    typedef struct packed {
        logic [HB-1:0] head;
        logic [CB-1:0] count;
    } t_meta;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INS,
        S_SCAN,
        S_POP
    } t_state;

    t_state                 r_state;
    logic [SB-1:0]          r_clr;
    logic [SB-1:0]          r_cur;
    logic [SB-1:0]          r_slot;
    logic [SB:0]            r_empties;
    logic [TIME_BITS-1:0]   r_time;
    logic [GATE_PORT_BITS-1:0] r_gate;

    // Per-slot head/count memory and gate entry memory
    t_meta                  meta_mem [SLOTS];
    t_meta                  r_meta_q;
    logic [GW-1:0]          entry_mem [SLOTS*SLOT_DEPTH];
    logic [GW-1:0]          r_entry_q;

    logic                   meta_rd_en;
    logic [SB-1:0]          meta_rd_addr;
    logic                   meta_we;
    logic [SB-1:0]          meta_wa;
    t_meta                  meta_wd;
    logic                   ent_we;
    logic                   ent_rd_en;
    logic [AB-1:0]          ent_addr;
    logic [GW-1:0]          ent_wd;

    logic [SB-1:0]          delay_tab [2**DELAY_BITS];
    logic [SB:0]            target_sum;
    logic [SB-1:0]          target_slot;
    logic [SB-1:0]          next_slot;
    logic [CB:0]            pos_sum;
    logic [HB-1:0]          ins_pos;
    logic [HB-1:0]          head_inc;
    logic [HB-1:0]          ent_off;
    logic                   slot_full;
    logic                   slot_hit;
    logic [31:0]            gate_in_ext;
    logic [31:0]            gate_out_ext;

    // Delay modulo SLOTS as a constant table
    for (genvar g = 0; g < 2**DELAY_BITS; g++) begin : g_dtab
        assign delay_tab[g] = SB'(g % SLOTS);
    end

    // Target slot: current position plus reduced delay, one wrap at most
    assign target_sum  = (SB+1)'(r_cur) + (SB+1)'(delay_tab[i_delay]);
    assign target_slot = (target_sum >= (SB+1)'(SLOTS)) ?
                         SB'(target_sum - (SB+1)'(SLOTS)) : SB'(target_sum);

    assign next_slot = (r_slot == SB'(SLOTS - 1)) ? '0 : r_slot + SB'(1);

    // Tail position and head advance within a slot
    assign pos_sum   = (CB+1)'(r_meta_q.head) + (CB+1)'(r_meta_q.count);
    assign ins_pos   = (pos_sum >= (CB+1)'(SLOT_DEPTH)) ?
                       HB'(pos_sum - (CB+1)'(SLOT_DEPTH)) : HB'(pos_sum);
    assign head_inc  = (r_meta_q.head == HB'(SLOT_DEPTH - 1)) ?
                       '0 : r_meta_q.head + HB'(1);
    assign slot_full = (r_meta_q.count == CB'(SLOT_DEPTH));
    assign slot_hit  = (r_meta_q.count != '0);

    assign ent_off  = (r_state == S_INS) ? ins_pos : r_meta_q.head;
    assign ent_addr = AB'(r_slot) * AB'(SLOT_DEPTH) + AB'(ent_off);

    assign gate_in_ext = 32'(r_gate);
    assign ent_wd      = gate_in_ext[GW-1:0];

    assign busy = (r_state != S_IDLE);

    // Memory port control
    always_comb begin
        meta_rd_en   = 1'b0;
        meta_rd_addr = r_cur;
        meta_we      = 1'b0;
        meta_wa      = r_slot;
        meta_wd      = '0;
        ent_we       = 1'b0;
        ent_rd_en    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                meta_we = 1'b1;
                meta_wa = r_clr;
            end
            S_IDLE: begin
                if (start) begin
                    meta_rd_en   = 1'b1;
                    meta_rd_addr = (i_cmd == CMD_INSERT) ? target_slot : r_cur;
                end
            end
            S_INS: begin
                if (!slot_full) begin
                    meta_we       = 1'b1;
                    meta_wd.head  = r_meta_q.head;
                    meta_wd.count = r_meta_q.count + CB'(1);
                    ent_we        = 1'b1;
                end
            end
            S_SCAN: begin
                // Read the next slot ahead; drop it on a hit
                meta_rd_en   = 1'b1;
                meta_rd_addr = next_slot;
                if (slot_hit) begin
                    meta_we       = 1'b1;
                    meta_wd.head  = head_inc;
                    meta_wd.count = r_meta_q.count - CB'(1);
                    ent_rd_en     = 1'b1;
                end
            end
            S_POP: begin
            end
            default: begin
            end
        endcase
    end

    // Meta memory
    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            meta_mem[meta_wa] <= meta_wd;
        end
        if (meta_rd_en) begin
            r_meta_q <= meta_mem[meta_rd_addr];
        end
    end

    // Entry memory
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            entry_mem[ent_addr] <= ent_wd;
        end
        if (ent_rd_en) begin
            r_entry_q <= entry_mem[ent_addr];
        end
    end

    assign gate_out_ext = 32'(r_entry_q);

    // Sequencer and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_cur     <= '0;
            r_time    <= '0;
            r_empties <= '0;
            o_done    <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + SB'(1);
                    if (r_clr == SB'(SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_gate <= i_gate_id;
                        if (i_cmd == CMD_INSERT) begin
                            r_slot  <= target_slot;
                            r_state <= S_INS;
                        end else begin
                            r_slot    <= r_cur;
                            r_empties <= '0;
                            r_state   <= S_SCAN;
                        end
                    end
                end
                S_INS: begin
                    o_done      <= 1'b1;
                    o_found     <= 1'b0;
                    o_next_gate <= '0;
                    o_time_now  <= r_time;
                    o_overflow  <= slot_full;
                    r_state     <= S_IDLE;
                end
                S_SCAN: begin
                    if (slot_hit) begin
                        r_cur   <= r_slot;
                        r_state <= S_POP;
                    end else begin
                        // Step past an empty slot
                        r_time <= r_time + TIME_BITS'(1);
                        if (r_empties == (SB+1)'(SLOTS - 1)) begin
                            r_cur       <= '0;
                            o_done      <= 1'b1;
                            o_found     <= 1'b0;
                            o_next_gate <= '0;
                            o_time_now  <= r_time + TIME_BITS'(1);
                            o_overflow  <= 1'b0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_slot    <= next_slot;
                            r_empties <= r_empties + (SB+1)'(1);
                        end
                    end
                end
                S_POP: begin
                    o_done      <= 1'b1;
                    o_found     <= 1'b1;
                    o_next_gate <= gate_out_ext[GATE_PORT_BITS-1:0];
                    o_time_now  <= r_time;
                    o_overflow  <= 1'b0;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A result strobe always coincides with the return to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // An accepted transaction makes the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accept did not raise busy");

    // A pop never reports an overflow
    a_found_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_found) |-> !o_overflow)
        else $error("found and overflow together");

    // An empty fetch returns gate zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_found) |-> (o_next_gate == '0))
        else $error("nonzero gate without a hit");

    // The scan never exceeds one full turn
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_empties < (SB+1)'(SLOTS)))
        else $error("scan ran past a full turn");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import dtw_pkg::*;

    localparam int SLOTS        = 64;
    localparam int SLOT_DEPTH   = 16;
    localparam int IDLE_LIMIT   = 4000;
    localparam int SETTLE_TICKS = 80;

    typedef struct packed {
        logic                      found;
        logic [GATE_PORT_BITS-1:0] gate;
        logic [TIME_BITS-1:0]      time_now;
        logic                      overflow;
    } t_wheel_result;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic                      i_cmd;
    logic [GATE_PORT_BITS-1:0] i_gate_id;
    logic [DELAY_BITS-1:0]     i_delay;
    logic                      o_done;
    logic                      o_found;
    logic [GATE_PORT_BITS-1:0] o_next_gate;
    logic [TIME_BITS-1:0]      o_time_now;
    logic                      o_overflow;

    delay_timing_wheel #(
        .SLOTS        (SLOTS),
        .SLOT_DEPTH   (SLOT_DEPTH),
        .GATE_ID_BITS (16)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_gate_id   (i_gate_id),
        .i_delay     (i_delay),
        .o_done      (o_done),
        .o_found     (o_found),
        .o_next_gate (o_next_gate),
        .o_time_now  (o_time_now),
        .o_overflow  (o_overflow)
    );

    // Clock: period 12
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Shadow copy of the wheel
    logic [GATE_PORT_BITS-1:0] slot_entry [SLOTS][SLOT_DEPTH];
    logic [3:0]                slot_rd_ptr [SLOTS];
    logic [4:0]                slot_fill [SLOTS];
    logic [5:0]                wheel_pos;
    logic [TIME_BITS-1:0]      sim_time;

    t_wheel_result pending_results [$];

    int n_sent;
    int n_checked;
    int n_errors;
    int n_inserts;
    int n_fetches;
    int n_hits;
    int n_dropped;
    int n_empty_rounds;
    int idle_cycles;
    bit gaps_on;

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            slot_rd_ptr[s] = '0;
            slot_fill[s]   = '0;
        end
        wheel_pos      = '0;
        sim_time       = '0;
        n_sent         = 0;
        n_checked      = 0;
        n_errors       = 0;
        n_inserts      = 0;
        n_fetches      = 0;
        n_hits         = 0;
        n_dropped      = 0;
        n_empty_rounds = 0;
        idle_cycles    = 0;
        gaps_on        = 1'b1;
    end

    // Advance the shadow wheel by one command and return the result it yields
    function automatic t_wheel_result schedule_event(t_cmd cmd, logic [GATE_PORT_BITS-1:0] gate,
                                                     logic [DELAY_BITS-1:0] dly);
        t_wheel_result res;
        logic [5:0]    target;
        logic [3:0]    wr_pos;
        int            steps;
        res = '0;
        if (cmd == CMD_INSERT) begin
            n_inserts++;
            target = wheel_pos + dly;
            if (slot_fill[target] >= SLOT_DEPTH) begin
                res.overflow = 1'b1;
                n_dropped++;
            end else begin
                wr_pos = slot_rd_ptr[target] + slot_fill[target][3:0];
                slot_entry[target][wr_pos] = gate;
                slot_fill[target] = slot_fill[target] + 5'd1;
            end
        end else begin
            n_fetches++;
            steps = 0;
            // Skip empty slots, one time tick each
            while (slot_fill[wheel_pos] == 0 && steps < SLOTS) begin
                wheel_pos = wheel_pos + 6'd1;
                sim_time  = sim_time + 48'd1;
                steps++;
            end
            if (steps == SLOTS) begin
                wheel_pos = '0;
                n_empty_rounds++;
            end else begin
                res.found = 1'b1;
                res.gate  = slot_entry[wheel_pos][slot_rd_ptr[wheel_pos]];
                slot_rd_ptr[wheel_pos] = slot_rd_ptr[wheel_pos] + 4'd1;
                slot_fill[wheel_pos]   = slot_fill[wheel_pos] - 5'd1;
                n_hits++;
            end
        end
        res.time_now = sim_time;
        return res;
    endfunction

    // Check each result strobe, record each accepted transaction, watch for a hang
    always @(posedge i_clk) begin
        t_wheel_result want;
        bit            moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_done) begin
                moved = 1'b1;
                if (pending_results.size() == 0) begin
                    $display("%0t: result with no transaction pending: %s=%0b %s=%h %s=%0d %s=%0b",
                             $time, "found", o_found, "gate", o_next_gate,
                             "time", o_time_now, "ovf", o_overflow);
                    n_errors++;
                end else begin
                    want = pending_results.pop_front();
                    n_checked++;
                    if (o_found !== want.found) begin
                        $display("%0t: found mismatch: expected %0b actual %0b",
                                 $time, want.found, o_found);
                        n_errors++;
                    end
                    if (o_next_gate !== want.gate) begin
                        $display("%0t: next_gate mismatch: expected %h actual %h",
                                 $time, want.gate, o_next_gate);
                        n_errors++;
                    end
                    if (o_time_now !== want.time_now) begin
                        $display("%0t: time_now mismatch: expected %0d actual %0d",
                                 $time, want.time_now, o_time_now);
                        n_errors++;
                    end
                    if (o_overflow !== want.overflow) begin
                        $display("%0t: overflow mismatch: expected %0b actual %0b",
                                 $time, want.overflow, o_overflow);
                        n_errors++;
                    end
                end
            end
            if (start && !busy) begin
                moved = 1'b1;
                pending_results.push_back(schedule_event(t_cmd'(i_cmd), i_gate_id, i_delay));
            end
        end
        if (moved) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Offer one transaction and hold it until the block takes it
    task automatic send_cmd(input t_cmd cmd, input logic [GATE_PORT_BITS-1:0] gate,
                            input logic [DELAY_BITS-1:0] dly);
        start     <= 1'b1;
        i_cmd     <= cmd;
        i_gate_id <= gate;
        i_delay   <= dly;
        do @(posedge i_clk); while (busy);
        n_sent++;
    endtask

    // Idle the sender for a random gap: mostly short, a few long
    task automatic sender_gap();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (!gaps_on || pick < 45) len = 0;
        else if (pick < 88) len = $urandom_range(1, 3);
        else if (pick < 97) len = $urandom_range(4, 12);
        else len = $urandom_range(20, 70);
        if (len > 0) begin
            start <= 1'b0;
            repeat (len) @(posedge i_clk);
        end
    endtask

    task automatic insert_gate(input logic [GATE_PORT_BITS-1:0] gate,
                               input logic [DELAY_BITS-1:0] dly);
        send_cmd(CMD_INSERT, gate, dly);
        sender_gap();
    endtask

    task automatic fetch_gate();
        send_cmd(CMD_FETCH, GATE_PORT_BITS'($urandom_range(0, 65535)),
                 DELAY_BITS'($urandom_range(0, 63)));
        sender_gap();
    endtask

    // Hold the sender off until every result is back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (n_checked < n_sent) @(posedge i_clk);
    endtask

    task automatic test_empty_fetch();
        fetch_gate();
    endtask

    // Delay 0 and delay SLOTS-1, two fetches that pop both, then a fetch over an empty wheel
    task automatic test_delay_extremes();
        insert_gate(16'hFFFF, 6'd0);
        insert_gate(16'h0000, 6'd63);
        fetch_gate();
        fetch_gate();
        fetch_gate();
    endtask

    // Fill one slot to the brim, then one more insert must be dropped
    task automatic test_slot_overflow();
        logic [DELAY_BITS-1:0] dly;
        dly = DELAY_BITS'($urandom_range(1, 62));
        for (int k = 0; k <= SLOT_DEPTH; k++) begin
            insert_gate(GATE_PORT_BITS'($urandom_range(0, 65535)), dly);
        end
    endtask

    task automatic test_pause_until_drained();
        drain_results();
    endtask

    task automatic test_random_mixed(input int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 1) == 0) begin
                insert_gate(GATE_PORT_BITS'($urandom_range(0, 65535)),
                            DELAY_BITS'($urandom_range(0, 63)));
            end else begin
                fetch_gate();
            end
        end
    endtask

    // Bursts of inserts into a narrow window of slots, then drain them and a bit past
    task automatic test_random_bursts(input int count);
        int done_cnt;
        int burst;
        int width;
        int extra;
        logic [DELAY_BITS-1:0] base;
        done_cnt = 0;
        while (done_cnt < count) begin
            burst = $urandom_range(1, 24);
            width = $urandom_range(0, 3);
            base  = DELAY_BITS'($urandom_range(0, 63));
            for (int k = 0; k < burst; k++) begin
                insert_gate(GATE_PORT_BITS'($urandom_range(0, 65535)),
                            base + DELAY_BITS'($urandom_range(0, width)));
            end
            extra = $urandom_range(0, 2);
            for (int k = 0; k < burst + extra; k++) begin
                fetch_gate();
            end
            done_cnt += 2 * burst + extra;
        end
    endtask

    task automatic test_random_back_to_back(input int count);
        gaps_on = 1'b0;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) < 6) begin
                insert_gate(GATE_PORT_BITS'($urandom_range(0, 65535)),
                            DELAY_BITS'($urandom_range(0, 63)));
            end else begin
                fetch_gate();
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        start     <= 1'b0;
        i_cmd     <= 1'b0;
        i_gate_id <= '0;
        i_delay   <= '0;
        i_rst_n   <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n   <= 1'b1;
        @(posedge i_clk);

        test_empty_fetch();
        test_delay_extremes();
        test_slot_overflow();
        test_pause_until_drained();
        test_random_mixed(300);
        test_random_bursts(300);
        test_random_back_to_back(150);

        drain_results();
        repeat (SETTLE_TICKS) @(posedge i_clk);

        $display("Sent %0d transactions: %0d inserts with %0d dropped on a full slot,",
                 n_sent, n_inserts, n_dropped);
        $display("%0d fetches with %0d gates returned and %0d full turns over an empty wheel.",
                 n_fetches, n_hits, n_empty_rounds);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== delay_timing_wheel.f =====
rtl/dtw_pkg.sv
rtl/delay_timing_wheel.sv
tb/tb_top.sv
